@@ hw/rtl/fpcvt_pkg.sv @@
// shared constants and types for the single/half precision converter
`timescale 1ns / 1ps

package fpcvt_pkg;

  typedef enum logic [0:0] {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } opcode_t;

  localparam int SGL_WIDTH      = 32;
  localparam int HALF_WIDTH     = 16;
  localparam int SGL_EXP_WIDTH  = 8;
  localparam int HALF_EXP_WIDTH = 5;
  localparam int SGL_MANT_BITS  = 23;
  localparam int HALF_MANT_BITS = 10;
  localparam int MANT_DROP      = SGL_MANT_BITS - HALF_MANT_BITS;

  localparam logic [SGL_EXP_WIDTH-1:0]  SGL_EXP_MAX  = 8'hff;
  localparam logic [HALF_EXP_WIDTH-1:0] HALF_EXP_MAX = 5'h1f;

  // biased single exponent range that maps to a normal half (unbiased -14..15)
  localparam logic [SGL_EXP_WIDTH-1:0] ENC_EXP_MIN = 8'd113;
  localparam logic [SGL_EXP_WIDTH-1:0] ENC_EXP_MAX = 8'd142;
  // single bias minus half bias
  localparam logic [SGL_EXP_WIDTH-1:0] EXP_REBIAS  = 8'd112;
  // single exponent of a half denormal whose leading one is at bit 0
  localparam logic [SGL_EXP_WIDTH-1:0] DENORM_EXP_BASE = 8'd103;

  localparam logic [HALF_MANT_BITS-1:0] NAN_QUIET = 10'h200;

endpackage

@@ hw/rtl/fpcvt_encode.sv @@
// binary32 to binary16 encoder, truncating, denormals flushed to zero
`timescale 1ns / 1ps

module fpcvt_encode (
  input  logic [fpcvt_pkg::SGL_WIDTH-1:0]  single_bits,
  output logic [fpcvt_pkg::HALF_WIDTH-1:0] half_bits
);

  logic                                    sign;
  logic [fpcvt_pkg::SGL_EXP_WIDTH-1:0]     exp_in;
  logic [fpcvt_pkg::SGL_MANT_BITS-1:0]     mant_in;
  logic [fpcvt_pkg::HALF_MANT_BITS-1:0]    mant_top;
  logic [fpcvt_pkg::SGL_EXP_WIDTH-1:0]     exp_rebiased;

  assign sign         = single_bits[fpcvt_pkg::SGL_WIDTH-1];
  assign exp_in       = single_bits[fpcvt_pkg::SGL_WIDTH-2:fpcvt_pkg::SGL_MANT_BITS];
  assign mant_in      = single_bits[fpcvt_pkg::SGL_MANT_BITS-1:0];
  assign mant_top     = mant_in[fpcvt_pkg::SGL_MANT_BITS-1:fpcvt_pkg::MANT_DROP];
  assign exp_rebiased = exp_in - fpcvt_pkg::EXP_REBIAS;

  always_comb begin
    priority if (exp_in == fpcvt_pkg::SGL_EXP_MAX) begin
      if (mant_in == '0) begin
        half_bits = {sign, fpcvt_pkg::HALF_EXP_MAX, {fpcvt_pkg::HALF_MANT_BITS{1'b0}}};
      end else if (mant_top == '0) begin
        // nan whose payload would vanish stays a nan
        half_bits = {sign, fpcvt_pkg::HALF_EXP_MAX, fpcvt_pkg::NAN_QUIET};
      end else begin
        half_bits = {sign, fpcvt_pkg::HALF_EXP_MAX, mant_top};
      end
    end else if (exp_in > fpcvt_pkg::ENC_EXP_MAX) begin
      half_bits = {sign, fpcvt_pkg::HALF_EXP_MAX, {fpcvt_pkg::HALF_MANT_BITS{1'b0}}};
    end else if (exp_in >= fpcvt_pkg::ENC_EXP_MIN) begin
      half_bits = {sign, exp_rebiased[fpcvt_pkg::HALF_EXP_WIDTH-1:0], mant_top};
    end else begin
      half_bits = {sign, {(fpcvt_pkg::HALF_WIDTH-1){1'b0}}};
    end
  end

endmodule

@@ hw/rtl/fpcvt_decode.sv @@
// binary16 to binary32 decoder, exact, half denormals normalized
`timescale 1ns / 1ps

module fpcvt_decode (
  input  logic [fpcvt_pkg::HALF_WIDTH-1:0] half_bits,
  output logic [fpcvt_pkg::SGL_WIDTH-1:0]  single_bits
);

  logic                                    sign;
  logic [fpcvt_pkg::HALF_EXP_WIDTH-1:0]    exp_in;
  logic [fpcvt_pkg::HALF_MANT_BITS-1:0]    mant_in;
  logic [3:0]                              lead_pos;
  logic [4:0]                              norm_shift;
  logic [fpcvt_pkg::SGL_MANT_BITS:0]       norm_mant;
  logic [fpcvt_pkg::SGL_EXP_WIDTH-1:0]     exp_denorm;
  logic [fpcvt_pkg::SGL_EXP_WIDTH-1:0]     exp_normal;
  logic [fpcvt_pkg::SGL_MANT_BITS-1:0]     mant_wide;

  assign sign    = half_bits[fpcvt_pkg::HALF_WIDTH-1];
  assign exp_in  = half_bits[fpcvt_pkg::HALF_WIDTH-2:fpcvt_pkg::HALF_MANT_BITS];
  assign mant_in = half_bits[fpcvt_pkg::HALF_MANT_BITS-1:0];

  // position of the leading one, highest set bit wins
  always_comb begin
    lead_pos = '0;
    for (int i = 0; i < fpcvt_pkg::HALF_MANT_BITS; i++) begin
      if (mant_in[i]) begin
        lead_pos = 4'(i);
      end
    end
  end

  // leading one lands on the hidden bit position and is dropped
  assign norm_shift = 5'(fpcvt_pkg::SGL_MANT_BITS) - {1'b0, lead_pos};
  assign norm_mant  = {{(fpcvt_pkg::SGL_MANT_BITS+1-fpcvt_pkg::HALF_MANT_BITS){1'b0}}, mant_in}
                      << norm_shift;
  assign exp_denorm = fpcvt_pkg::DENORM_EXP_BASE + {4'b0, lead_pos};
  assign exp_normal = {3'b0, exp_in} + fpcvt_pkg::EXP_REBIAS;
  assign mant_wide  = {mant_in, {fpcvt_pkg::MANT_DROP{1'b0}}};

  always_comb begin
    priority if (exp_in == '0) begin
      if (mant_in == '0) begin
        single_bits = {sign, {(fpcvt_pkg::SGL_WIDTH-1){1'b0}}};
      end else begin
        single_bits = {sign, exp_denorm, norm_mant[fpcvt_pkg::SGL_MANT_BITS-1:0]};
      end
    end else if (exp_in == fpcvt_pkg::HALF_EXP_MAX) begin
      single_bits = {sign, fpcvt_pkg::SGL_EXP_MAX, mant_wide};
    end else begin
      single_bits = {sign, exp_normal, mant_wide};
    end
  end

endmodule

@@ hw/rtl/fp32_fp16_converter_top.sv @@
// Converter between IEEE binary32 and binary16 bit patterns. opcode 0 encodes single_bits
// to a half in result_bits[15:0] (truncated, overflow to infinity, small values and
// denormals to signed zero); opcode 1 decodes half_bits exactly to a single. One
// transaction is accepted every cycle while in_ready is high; each passes through the input
// register, one level of conversion logic and the result register. A stalled output holds the
// result register, and also a full input register, in which case in_ready drops.
`timescale 1ns / 1ps

module fp32_fp16_converter_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                opcode,
  input  logic [fpcvt_pkg::SGL_WIDTH-1:0]     single_bits,
  input  logic [fpcvt_pkg::HALF_WIDTH-1:0]    half_bits,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [fpcvt_pkg::SGL_WIDTH-1:0]     result_bits
);

  logic                                  stage_valid;
  fpcvt_pkg::opcode_t                    stage_opcode;
  logic [fpcvt_pkg::SGL_WIDTH-1:0]       stage_single;
  logic [fpcvt_pkg::HALF_WIDTH-1:0]      stage_half;
  logic                                  stage_advance;
  logic [fpcvt_pkg::HALF_WIDTH-1:0]      enc_bits;
  logic [fpcvt_pkg::SGL_WIDTH-1:0]       dec_bits;
  logic [fpcvt_pkg::SGL_WIDTH-1:0]       result_next;

  assign stage_advance = !out_valid || out_ready;
  assign in_ready      = !stage_valid || stage_advance;

  fpcvt_encode u_encode (
    .single_bits (stage_single),
    .half_bits   (enc_bits)
  );

  fpcvt_decode u_decode (
    .half_bits   (stage_half),
    .single_bits (dec_bits)
  );

  always_comb begin
    unique case (stage_opcode)
      fpcvt_pkg::OP_ENCODE: result_next = {{(fpcvt_pkg::SGL_WIDTH-fpcvt_pkg::HALF_WIDTH){1'b0}},
                                           enc_bits};
      fpcvt_pkg::OP_DECODE: result_next = dec_bits;
      default:              result_next = dec_bits;
    endcase
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      stage_opcode <= fpcvt_pkg::opcode_t'(opcode);
      stage_single <= single_bits;
      stage_half   <= half_bits;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_advance) begin
      out_valid <= stage_valid;
    end
    if (stage_advance && stage_valid) begin
      result_bits <= result_next;
    end
  end

endmodule
